// ===== hdl/boid_neighbour_accumulator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BOID_NEIGHBOUR_ACCUMULATOR_ASSERT_SVH
`define BOID_NEIGHBOUR_ACCUMULATOR_ASSERT_SVH
// Clocked assertion with reset disable.
`define BNA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Implication held over the next cycle.
`define BNA_ASSERT_NEXT(label, pre, post, msg) \
	`BNA_ASSERT(label, (pre) |=> (post), msg)
`endif

// ===== hdl/bna_pkg.sv =====
// Shared constants, types and helper functions for the boid neighbour accumulator.
`timescale 1ns / 1ps
`default_nettype none
package bna_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MASS_FRAC = 8;
	localparam int POS_W = 32;
	localparam int DIFF_W = POS_W + 1;
	localparam int MASS_W = 16;
	localparam int RAD_W = 31;
	localparam int ACC_W = 48;
	localparam int TERM_W = 42;
	localparam int PROD_W = DIFF_W + MASS_W + 1;
	localparam int SQ_W = 2 * POS_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int RSQ_W = 2 * RAD_W;
	localparam int DIV_BITS = POS_W + MASS_FRAC;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);
	localparam int MSUM_W = 32;
	localparam int CNT_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] CLOSE_RAW = 64'd10 << FRAC_BITS;
	localparam logic [63:0] NEAR_RAW = 64'd250 << FRAC_BITS;
	localparam logic [63:0] RAD_MAX = (64'd1 << RAD_W) - 64'd1;
	localparam logic [RAD_W-1:0] CLOSE_RESET =
		(CLOSE_RAW > RAD_MAX) ? RAD_MAX[RAD_W-1:0] : CLOSE_RAW[RAD_W-1:0];
	localparam logic [RAD_W-1:0] NEAR_RESET =
		(NEAR_RAW > RAD_MAX) ? RAD_MAX[RAD_W-1:0] : NEAR_RAW[RAD_W-1:0];

	localparam logic [1:0] REG_CLOSE = 2'd0;
	localparam logic [1:0] REG_NEAR = 2'd1;

	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_CLOSE = 2'd1;
	localparam logic [1:0] CLS_NEAR = 2'd2;

	localparam logic [1:0] KIND_SEP = 2'd0;
	localparam logic [1:0] KIND_COH = 2'd1;
	localparam logic [1:0] KIND_ALI = 2'd2;

	// Classified item handed from front to back: a holds the displacement for
	// close items, the sign-extended position for other candidates and zero for a focus load.
	typedef struct packed {
		logic [1:0] cls;
		logic last;
		logic [2:0][DIFF_W-1:0] a;
		logic [2:0][POS_W-1:0] v;
		logic [MASS_W-1:0] mass;
	} job_t;

	typedef struct packed {
		logic valid;
		logic [1:0] kind;
		logic [2:0][ACC_W-1:0] sum;
		logic [MSUM_W-1:0] mass_sum;
		logic [CNT_W-1:0] count;
		logic end_of_run;
	} result_t;

	function automatic logic [POS_W-1:0] mag_diff(input logic [DIFF_W-1:0] x);
		logic [DIFF_W-1:0] t;
		t = x[DIFF_W-1] ? -x : x;
		return t[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] mag_pos(input logic [POS_W-1:0] x);
		return x[POS_W-1] ? -x : x;
	endfunction

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
			input logic [TERM_W-1:0] term);
		logic [ACC_W:0] s;
		s = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - TERM_W){term[TERM_W-1]}}, term};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== hdl/boid_neighbour_accumulator.sv =====
// The front classifies a candidate with one shared 32x32 multiplier (eight products);
// the back runs three 40-step cohesion divisions per near boid, none per close boid.
// Throughput is set by the back for near boids and by the front multiplier otherwise.
// Emitting a run takes three result beats. Reset restores the default radii,
// clears the focus boid and every accumulator; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module boid_neighbour_accumulator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [bna_pkg::RAD_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [bna_pkg::POS_W-1:0] pos_x,
	input wire logic [bna_pkg::POS_W-1:0] pos_y,
	input wire logic [bna_pkg::POS_W-1:0] pos_z,
	input wire logic [bna_pkg::POS_W-1:0] vel_x,
	input wire logic [bna_pkg::POS_W-1:0] vel_y,
	input wire logic [bna_pkg::POS_W-1:0] vel_z,
	input wire logic [bna_pkg::MASS_W-1:0] mass,
	input wire logic last,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic [bna_pkg::ACC_W-1:0] sum_x,
	output logic [bna_pkg::ACC_W-1:0] sum_y,
	output logic [bna_pkg::ACC_W-1:0] sum_z,
	output logic [bna_pkg::MSUM_W-1:0] mass_sum,
	output logic [bna_pkg::CNT_W-1:0] count,
	output logic end_of_run
);
	logic push, full, pop, empty;
	bna_pkg::job_t job, head;
	bna_pkg::result_t res;

	assign cfg_ready = 1'b1;

	bna_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.pos({pos_z, pos_y, pos_x}),
		.vel({vel_z, vel_y, vel_x}),
		.mass(mass),
		.last(last),
		.push(push),
		.full(full),
		.job(job)
	);

	bna_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(job),
		.full(full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	bna_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.res(res),
		.out_stall(out_stall)
	);

	assign out_valid = res.valid;
	assign kind = res.kind;
	assign sum_x = res.sum[0];
	assign sum_y = res.sum[1];
	assign sum_z = res.sum[2];
	assign mass_sum = res.mass_sum;
	assign count = res.count;
	assign end_of_run = res.end_of_run;
endmodule
`default_nettype wire

// ===== hdl/bna_front.sv =====
// Front end: accepts items, holds the focus boid and classifies each candidate.
`timescale 1ns / 1ps
`default_nettype none
module bna_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr,
	input wire logic [1:0] cfg_index,
	input wire logic [bna_pkg::RAD_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [2:0][bna_pkg::POS_W-1:0] pos,
	input wire logic [2:0][bna_pkg::POS_W-1:0] vel,
	input wire logic [bna_pkg::MASS_W-1:0] mass,
	input wire logic last,
	output logic push,
	input wire logic full,
	output bna_pkg::job_t job
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CALC = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;
	localparam logic [3:0] STEP_CLASSIFY = 4'd9;

	logic [1:0] state_q;
	logic [bna_pkg::RAD_W-1:0] rc_q, rn_q;
	logic [2:0][bna_pkg::POS_W-1:0] fp_q, fv_q, p_q, v_q;
	logic [2:0][bna_pkg::DIFF_W-1:0] d_q;
	logic [bna_pkg::MASS_W-1:0] mass_q;
	logic last_q;
	logic [3:0] step_q;
	logic [bna_pkg::SQ_W-1:0] prod_q;
	logic [bna_pkg::SUM_W-1:0] dist_q, pdot_q, ndot_q;
	logic [bna_pkg::RSQ_W-1:0] rc2_q, rn2_q;
	bna_pkg::job_t job_q;

	logic [2:0][bna_pkg::POS_W-1:0] dmag, fvmag, vmag;
	logic [2:0] sdiff;
	logic [bna_pkg::POS_W-1:0] mul_a, mul_b;
	logic [3:0] sm3, prev;
	logic fz, cz, nonzero, visible, is_close, is_near;
	logic accept;

	assign in_stall = (state_q != F_IDLE);
	assign accept = in_valid && !in_stall;
	assign push = (state_q == F_PUSH) && !full;
	assign job = job_q;
	assign sm3 = step_q - 4'd3;
	assign prev = step_q - 4'd1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = bna_pkg::mag_diff(d_q[i]);
			fvmag[i] = bna_pkg::mag_pos(fv_q[i]);
			vmag[i] = bna_pkg::mag_pos(v_q[i]);
			sdiff[i] = fv_q[i][bna_pkg::POS_W-1] ^ v_q[i][bna_pkg::POS_W-1];
		end
	end

	// One shared multiplier: three squares, three dot terms, two radii.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q) inside
			4'd0, 4'd1, 4'd2: begin
				mul_a = dmag[step_q[1:0]];
				mul_b = dmag[step_q[1:0]];
			end
			4'd3, 4'd4, 4'd5: begin
				mul_a = fvmag[sm3[1:0]];
				mul_b = vmag[sm3[1:0]];
			end
			4'd6: begin
				mul_a = {1'b0, rc_q};
				mul_b = {1'b0, rc_q};
			end
			4'd7: begin
				mul_a = {1'b0, rn_q};
				mul_b = {1'b0, rn_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		fz = (fv_q == '0);
		cz = (v_q == '0);
		nonzero = (dist_q != '0);
		visible = fz || cz || (pdot_q > ndot_q);
		is_close = nonzero && visible && (dist_q < {4'b0, rc2_q});
		is_near = nonzero && visible && (dist_q < {4'b0, rn2_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			rc_q <= bna_pkg::CLOSE_RESET;
			rn_q <= bna_pkg::NEAR_RESET;
			fp_q <= '0;
			fv_q <= '0;
			step_q <= '0;
		end else begin
			if (cfg_wr) begin
				if (cfg_index == bna_pkg::REG_CLOSE)
					rc_q <= cfg_data;
				else if (cfg_index == bna_pkg::REG_NEAR)
					rn_q <= cfg_data;
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (!cmd) begin
							fp_q <= pos;
							fv_q <= vel;
							state_q <= F_PUSH;
						end else begin
							step_q <= '0;
							state_q <= F_CALC;
						end
					end
				end
				F_CALC: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_CLASSIFY)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q <= pos;
			v_q <= vel;
			mass_q <= mass;
			last_q <= last;
			for (int i = 0; i < 3; i++)
				d_q[i] <= {fp_q[i][bna_pkg::POS_W-1], fp_q[i]} - {pos[i][bna_pkg::POS_W-1], pos[i]};
			dist_q <= '0;
			pdot_q <= '0;
			ndot_q <= '0;
			if (!cmd) begin
				job_q.cls <= bna_pkg::CLS_NONE;
				job_q.last <= last;
				job_q.a <= '0;
				job_q.v <= '0;
				job_q.mass <= mass;
			end
		end
		if (state_q == F_CALC) begin
			prod_q <= mul_a * mul_b;
			case (prev) inside
				4'd0, 4'd1, 4'd2: dist_q <= dist_q + {2'b0, prod_q};
				4'd3, 4'd4, 4'd5: begin
					if (sdiff[sm3[1:0] - 2'd1])
						ndot_q <= ndot_q + {2'b0, prod_q};
					else
						pdot_q <= pdot_q + {2'b0, prod_q};
				end
				4'd6: rc2_q <= prod_q[bna_pkg::RSQ_W-1:0];
				4'd7: rn2_q <= prod_q[bna_pkg::RSQ_W-1:0];
				default: ;
			endcase
			if (step_q == STEP_CLASSIFY) begin
				job_q.cls <= is_close ? bna_pkg::CLS_CLOSE :
					(is_near ? bna_pkg::CLS_NEAR : bna_pkg::CLS_NONE);
				job_q.last <= last_q;
				job_q.v <= v_q;
				job_q.mass <= mass_q;
				for (int i = 0; i < 3; i++)
					job_q.a[i] <= is_close ? d_q[i] : {p_q[i][bna_pkg::POS_W-1], p_q[i]};
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/bna_queue.sv =====
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bna_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bna_pkg::job_t push_data,
	output logic full,
	input wire logic pop,
	output logic empty,
	output bna_pkg::job_t head
);
	bna_pkg::job_t mem_q [bna_pkg::QUEUE_DEPTH];
	logic [bna_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [bna_pkg::QPTR_W:0] fill_q;

	assign full = (fill_q == (bna_pkg::QPTR_W + 1)'(bna_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end
endmodule
`default_nettype wire

// ===== hdl/bna_back.sv =====
// Back end: accumulates classified items and emits the three sums per run.
`timescale 1ns / 1ps
`default_nettype none
module bna_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire bna_pkg::job_t head,
	output logic pop,
	output bna_pkg::result_t res,
	input wire logic out_stall
);
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL = 3'd1;
	localparam logic [2:0] B_DIV = 3'd2;
	localparam logic [2:0] B_TALLY = 3'd3;
	localparam logic [2:0] B_EMIT = 3'd4;

	localparam int DW = bna_pkg::DIV_BITS;
	localparam int MW = bna_pkg::MASS_W;

	logic [2:0] state_q;
	bna_pkg::job_t job_q;
	logic [1:0] step_q;
	logic [1:0] comp_q;
	logic [1:0] k_q;
	logic signed [bna_pkg::PROD_W-1:0] prod_q;
	logic [DW-1:0] dvd_q;
	logic [MW-1:0] rem_q;
	logic [bna_pkg::DIV_CNT_W-1:0] cnt_q;
	logic neg_q;
	logic [2:0][bna_pkg::ACC_W-1:0] sep_q, coh_q, ali_q;
	logic [bna_pkg::MSUM_W-1:0] cmass_q, nmass_q;
	logic [bna_pkg::CNT_W-1:0] ctally_q, ntally_q;
	bna_pkg::result_t res_q;

	logic close_job;
	logic [bna_pkg::DIFF_W-1:0] mop;
	logic [1:0] pidx;
	logic [bna_pkg::TERM_W-1:0] mterm, dterm;
	logic [MW-1:0] divisor;
	logic [MW:0] trial, trial_sub;
	logic [bna_pkg::MSUM_W:0] msum_next;
	logic load_out;

	assign close_job = (job_q.cls == bna_pkg::CLS_CLOSE);
	assign pop = (state_q == B_IDLE) && !empty;
	assign res = res_q;
	assign pidx = step_q - 2'd1;
	assign divisor = (job_q.mass == '0) ? MW'(1) : job_q.mass;
	assign trial = {rem_q, dvd_q[DW-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign load_out = (state_q == B_EMIT) && (!res_q.valid || !out_stall);

	always_comb begin
		mop = close_job ? job_q.a[step_q] :
			{job_q.v[step_q][bna_pkg::POS_W-1], job_q.v[step_q]};
		mterm = prod_q[bna_pkg::PROD_W-1:bna_pkg::MASS_FRAC];
		dterm = neg_q ? -{2'b0, dvd_q} : {2'b0, dvd_q};
		msum_next = {1'b0, close_job ? cmass_q : nmass_q} + {17'b0, job_q.mass};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
			comp_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			sep_q <= '0;
			coh_q <= '0;
			ali_q <= '0;
			cmass_q <= '0;
			nmass_q <= '0;
			ctally_q <= '0;
			ntally_q <= '0;
			res_q <= '0;
		end else begin
			if (load_out)
				res_q.valid <= 1'b1;
			else if (!out_stall)
				res_q.valid <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						step_q <= '0;
						k_q <= '0;
						if (head.cls == bna_pkg::CLS_CLOSE || head.cls == bna_pkg::CLS_NEAR)
							state_q <= B_MUL;
						else if (head.last)
							state_q <= B_EMIT;
					end
				end
				B_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q != 2'd0) begin
						if (close_job)
							sep_q[pidx] <= bna_pkg::sat_add(sep_q[pidx], mterm);
						else
							ali_q[pidx] <= bna_pkg::sat_add(ali_q[pidx], mterm);
					end
					if (step_q == 2'd3) begin
						comp_q <= '0;
						cnt_q <= '0;
						state_q <= close_job ? B_TALLY : B_DIV;
					end
				end
				B_DIV: begin
					// One quotient bit per cycle, then the term is added.
					if (cnt_q == bna_pkg::DIV_CNT_W'(DW)) begin
						coh_q[comp_q] <= bna_pkg::sat_add(coh_q[comp_q], dterm);
						cnt_q <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2)
							state_q <= B_TALLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_TALLY: begin
					if (close_job) begin
						cmass_q <= msum_next[bna_pkg::MSUM_W] ? '1 : msum_next[bna_pkg::MSUM_W-1:0];
						if (ctally_q != '1)
							ctally_q <= ctally_q + 1'b1;
					end else begin
						nmass_q <= msum_next[bna_pkg::MSUM_W] ? '1 : msum_next[bna_pkg::MSUM_W-1:0];
						if (ntally_q != '1)
							ntally_q <= ntally_q + 1'b1;
					end
					state_q <= job_q.last ? B_EMIT : B_IDLE;
				end
				B_EMIT: begin
					if (load_out) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd2) begin
							sep_q <= '0;
							coh_q <= '0;
							ali_q <= '0;
							cmass_q <= '0;
							nmass_q <= '0;
							ctally_q <= '0;
							ntally_q <= '0;
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load_out) begin
				res_q.end_of_run <= (k_q == 2'd2);
				case (k_q)
					2'd0: begin
						res_q.kind <= bna_pkg::KIND_SEP;
						res_q.sum <= sep_q;
						res_q.mass_sum <= cmass_q;
						res_q.count <= ctally_q;
					end
					2'd1: begin
						res_q.kind <= bna_pkg::KIND_COH;
						res_q.sum <= coh_q;
						res_q.mass_sum <= nmass_q;
						res_q.count <= ntally_q;
					end
					default: begin
						res_q.kind <= bna_pkg::KIND_ALI;
						res_q.sum <= ali_q;
						res_q.mass_sum <= nmass_q;
						res_q.count <= ntally_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (state_q == B_MUL)
			prod_q <= $signed(mop) * $signed({1'b0, job_q.mass});
		if ((state_q == B_MUL && step_q == 2'd3) ||
				(state_q == B_DIV && cnt_q == bna_pkg::DIV_CNT_W'(DW) && comp_q != 2'd2)) begin
			// Load the dividend |p| * 256 for the next component.
			if (state_q == B_MUL) begin
				dvd_q <= {bna_pkg::mag_diff(job_q.a[0]), {bna_pkg::MASS_FRAC{1'b0}}};
				neg_q <= job_q.a[0][bna_pkg::DIFF_W-1];
			end else begin
				dvd_q <= {bna_pkg::mag_diff(job_q.a[comp_q + 2'd1]), {bna_pkg::MASS_FRAC{1'b0}}};
				neg_q <= job_q.a[comp_q + 2'd1][bna_pkg::DIFF_W-1];
			end
			rem_q <= '0;
		end else if (state_q == B_DIV && cnt_q != bna_pkg::DIV_CNT_W'(DW)) begin
			if (!trial_sub[MW]) begin
				rem_q <= trial_sub[MW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[MW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/bna_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "boid_neighbour_accumulator_assert.svh"
module bna_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] kind,
	input wire logic end_of_run
);
	`BNA_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid, "result valid dropped while stalled")
	`BNA_ASSERT_NEXT(a_kind_holds, out_valid && out_stall, $stable(kind), "result kind changed while stalled")
	`BNA_ASSERT_NEXT(a_sep_then_coh, out_valid && !out_stall && kind == bna_pkg::KIND_SEP, out_valid && kind == bna_pkg::KIND_COH && !end_of_run, "cohesion beat does not follow separation")
	`BNA_ASSERT_NEXT(a_coh_then_ali, out_valid && !out_stall && kind == bna_pkg::KIND_COH, out_valid && kind == bna_pkg::KIND_ALI && end_of_run, "alignment beat does not follow cohesion")
endmodule

bind boid_neighbour_accumulator bna_checker u_bna_checker (.*);
`default_nettype wire
